FILE: hw/rtl/fmd_pkg.sv
// ----------------------------------------------------------------------------
// fmd_pkg
// shared types and constants of the frame motion detector
// ----------------------------------------------------------------------------
`default_nettype none

package fmd_pkg;

    localparam int GREY_W    = 10;
    localparam int COLSUM_W  = 12;
    localparam int BLUR_W    = 13;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 21;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION = 2'd3;

    typedef struct packed {
        logic valid;
        logic kind;
        logic first;
        logic fin;
    } emit_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fmd_ram.sv
// ----------------------------------------------------------------------------
// fmd_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fmd_blur.sv
// ----------------------------------------------------------------------------
// fmd_blur
// 3x3 box sum over the grey stream using a two-row line memory and a
// column-sum window
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_blur #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int AW = CW + $clog2(MAX_HEIGHT)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          line_we,
    input  logic [CW-1:0]                 col,
    input  logic [fmd_pkg::GREY_W-1:0]    grey,
    input  logic                          use_l1,
    input  logic                          use_l2,
    input  logic                          col_zero,
    input  fmd_pkg::emit_ctl_t            ctl,
    input  logic [AW-1:0]                 center,
    output fmd_pkg::emit_ctl_t            ctl_out,
    output logic [fmd_pkg::BLUR_W-1:0]    blur_out,
    output logic [AW-1:0]                 center_out
);

    import fmd_pkg::*;

    logic                v1_reg;
    logic                we1_reg;
    logic [CW-1:0]       col1_reg;
    logic [GREY_W-1:0]   grey1_reg;
    logic                l1use_reg;
    logic                l2use_reg;
    logic                czero_reg;
    emit_ctl_t           ctl1_reg;
    logic [AW-1:0]       center1_reg;
    logic [COLSUM_W-1:0] cs_a_reg;
    logic [COLSUM_W-1:0] cs_b_reg;
    emit_ctl_t           ctl2_reg;
    logic [BLUR_W-1:0]   blur2_reg;
    logic [AW-1:0]       center2_reg;

    logic [2*GREY_W-1:0] line_rd;
    logic [GREY_W-1:0]   l1;
    logic [GREY_W-1:0]   l2;
    logic [COLSUM_W-1:0] cs;
    logic [BLUR_W-1:0]   blur_next;

    // word holds {row above, two rows above}
    fmd_ram #(
        .WIDTH(2 * GREY_W),
        .DEPTH(MAX_WIDTH)
    ) u_line (
        .clk  (clk),
        .we   (v1_reg && we1_reg),
        .waddr(col1_reg),
        .wdata({grey1_reg, l1}),
        .re   (step),
        .raddr(col),
        .rdata(line_rd)
    );

    assign l1 = line_rd[2*GREY_W-1:GREY_W];
    assign l2 = line_rd[GREY_W-1:0];

    always_comb
    begin
        cs = COLSUM_W'(grey1_reg)
           + (l1use_reg ? COLSUM_W'(l1) : '0)
           + (l2use_reg ? COLSUM_W'(l2) : '0);
        if (czero_reg)
        begin
            blur_next = BLUR_W'(cs_a_reg) + BLUR_W'(cs_b_reg);
        end
        else
        begin
            blur_next = BLUR_W'(cs_a_reg) + BLUR_W'(cs_b_reg) + BLUR_W'(cs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            cs_a_reg <= '0;
            cs_b_reg <= '0;
        end
        else
        begin
            v1_reg   <= step;
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
            if (v1_reg)
            begin
                cs_a_reg <= cs;
                cs_b_reg <= czero_reg ? '0 : cs_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        we1_reg     <= line_we;
        col1_reg    <= col;
        grey1_reg   <= grey;
        l1use_reg   <= use_l1;
        l2use_reg   <= use_l2;
        czero_reg   <= col_zero;
        center1_reg <= center;
        blur2_reg   <= blur_next;
        center2_reg <= center1_reg;
    end

    assign ctl_out    = ctl2_reg;
    assign blur_out   = blur2_reg;
    assign center_out = center2_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fmd_bgcmp.sv
// ----------------------------------------------------------------------------
// fmd_bgcmp
// double-banked background store, difference test and changed-pixel count
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_bgcmp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int AW   = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT),
    localparam int CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fmd_pkg::emit_ctl_t            ctl,
    input  logic [fmd_pkg::BLUR_W-1:0]    blur,
    input  logic [AW-1:0]                 center,
    input  logic [fmd_pkg::BLUR_W-1:0]    threshold,
    output logic                          done,
    output logic [CNTW-1:0]               count
);

    import fmd_pkg::*;

    logic              bank_reg;
    logic              v3_reg;
    logic              first3_reg;
    logic              fin3_reg;
    logic [BLUR_W-1:0] blur3_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              done_reg;

    logic [BLUR_W-1:0] bg_rd;
    logic [BLUR_W-1:0] diff;
    logic              hit;
    logic [CNTW-1:0]   cnt_next;

    // background frames fill the idle bank, which becomes live at frame end
    fmd_ram #(
        .WIDTH(BLUR_W),
        .DEPTH(2 ** (AW + 1))
    ) u_bg (
        .clk  (clk),
        .we   (ctl.valid && !ctl.kind),
        .waddr({~bank_reg, center}),
        .wdata(blur),
        .re   (ctl.valid && ctl.kind),
        .raddr({bank_reg, center}),
        .rdata(bg_rd)
    );

    always_comb
    begin
        diff     = (blur3_reg >= bg_rd) ? (blur3_reg - bg_rd) : (bg_rd - blur3_reg);
        hit      = diff >= threshold;
        cnt_next = (first3_reg ? '0 : cnt_reg) + CNTW'(hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg   <= 1'b0;
            v3_reg     <= 1'b0;
            first3_reg <= 1'b0;
            fin3_reg   <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.valid && !ctl.kind && ctl.fin)
            begin
                bank_reg <= ~bank_reg;
            end
            v3_reg     <= ctl.valid && ctl.kind;
            first3_reg <= ctl.first;
            fin3_reg   <= ctl.fin;
            if (v3_reg)
            begin
                cnt_reg <= cnt_next;
            end
            done_reg <= v3_reg && fin3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        blur3_reg <= blur;
    end

    assign done  = done_reg;
    assign count = cnt_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/frame_motion_detector_core.sv
// ----------------------------------------------------------------------------
// frame_motion_detector_core
// background-subtraction motion detector with a 3x3 box blur
// ----------------------------------------------------------------------------
// One pixel is taken per clock. After the last pixel of every frame the input
// stalls while the position sequencer sweeps the bottom padding row through the
// line memory to finish the blur; a test frame's result leaves after that sweep,
// and the sweep of a test frame waits while the previous result is still untaken.
// The background store is two banks in one memory, so a background frame only
// goes live once it is complete.
`default_nettype none

module frame_motion_detector_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // red, green, blue
    input  logic                              s_tuser,   // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // changed_count
    output logic                              m_tuser,   // motion
    input  logic                              cfg_we,
    input  logic [fmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fmd_pkg::CFG_W-1:0]         cfg_data
);

    import fmd_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int HB   = $clog2(MAX_HEIGHT);
    localparam int AW   = CW + HB;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 2);
    localparam int CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    logic [10:0]          cfg_width_reg;
    logic [10:0]          cfg_height_reg;
    logic [BLUR_W-1:0]    thresh_reg;
    logic [CFG_W-1:0]     fraction_reg;
    logic [WW+HW-1:0]     wh_reg;
    logic [CFG_W+WW+HW-1:0] prod_reg;

    logic [RW-1:0]        row_reg;
    logic [CW-1:0]        col_reg;
    logic                 flushing_reg;
    logic                 kind_reg;

    logic                 out_valid_reg;
    logic                 motion_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic [WW-1:0]        w_eff;
    logic [HW-1:0]        h_eff;
    logic                 flush_go;
    logic                 accept;
    logic                 step;
    logic                 at_origin;
    logic                 frame_kind;
    logic                 last_col;
    logic                 row_last;
    logic                 row_h;
    logic                 col_zero;
    logic                 r_ge1;
    logic                 r_ge2;
    logic [GREY_W-1:0]    grey;
    logic [RW-1:0]        center_row;
    logic [CW-1:0]        center_col;
    emit_ctl_t            emit_ctl;
    emit_ctl_t            blur_ctl;
    logic [BLUR_W-1:0]    blur_val;
    logic [AW-1:0]        blur_center;
    logic                 done;
    logic [CNTW-1:0]      count;
    logic [31:0]          count32;

    always_comb
    begin
        if (int'(cfg_width_reg) < 3)
            w_eff = WW'(3);
        else if (int'(cfg_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg_width_reg);
        if (int'(cfg_height_reg) < 3)
            h_eff = HW'(3);
        else if (int'(cfg_height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(cfg_height_reg);
    end

    assign flush_go   = !out_valid_reg || !kind_reg;
    assign s_tready   = !flushing_reg;
    assign accept     = s_tvalid && s_tready;
    assign step       = accept || (flushing_reg && flush_go);
    assign at_origin  = !flushing_reg && row_reg == '0 && col_reg == '0;
    assign frame_kind = at_origin ? s_tuser : kind_reg;
    assign last_col   = WW'(col_reg) == w_eff - WW'(1);
    assign row_last   = row_reg == RW'(h_eff) - RW'(1);
    assign row_h      = row_reg == RW'(h_eff);
    assign col_zero   = col_reg == '0;
    assign r_ge1      = row_reg != '0;
    assign r_ge2      = row_reg > RW'(1);

    always_comb
    begin
        if (flushing_reg)
            grey = '0;
        else
            grey = GREY_W'(s_tdata[7:0]) + GREY_W'(s_tdata[15:8]) + GREY_W'(s_tdata[23:16]);
        if (col_zero)
        begin
            center_row = row_reg - RW'(2);
            center_col = CW'(w_eff - WW'(1));
        end
        else
        begin
            center_row = row_reg - RW'(1);
            center_col = col_reg - CW'(1);
        end
        emit_ctl.valid = step && (col_zero ? r_ge2 : r_ge1);
        emit_ctl.kind  = frame_kind;
        emit_ctl.first = row_reg == RW'(1) && col_reg == CW'(1);
        emit_ctl.fin   = flushing_reg && row_reg == RW'(h_eff) + RW'(1);
    end

    fmd_blur #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_blur (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .line_we   (!flushing_reg),
        .col       (col_reg),
        .grey      (grey),
        .use_l1    (r_ge1),
        .use_l2    (r_ge2),
        .col_zero  (col_zero),
        .ctl       (emit_ctl),
        .center    ({center_row[HB-1:0], center_col}),
        .ctl_out   (blur_ctl),
        .blur_out  (blur_val),
        .center_out(blur_center)
    );

    fmd_bgcmp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_bgcmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (blur_ctl),
        .blur     (blur_val),
        .center   (blur_center),
        .threshold(thresh_reg),
        .done     (done),
        .count    (count)
    );

    assign count32 = 32'(count);

    // configuration registers and size products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= 11'd640;
            cfg_height_reg <= 11'd480;
            thresh_reg     <= 13'd77;
            fraction_reg   <= 17'd6554;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:    cfg_width_reg  <= cfg_data[10:0];
                REG_HEIGHT:   cfg_height_reg <= cfg_data[10:0];
                REG_THRESH:   thresh_reg     <= cfg_data[BLUR_W-1:0];
                REG_FRACTION: fraction_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        wh_reg   <= (WW+HW)'(w_eff) * (WW+HW)'(h_eff);
        prod_reg <= (CFG_W+WW+HW)'(fraction_reg) * (CFG_W+WW+HW)'(wh_reg);
    end

    // position sequencer, including the bottom padding sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            flushing_reg <= 1'b0;
            kind_reg     <= 1'b0;
        end
        else if (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT))
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            flushing_reg <= 1'b0;
        end
        else if (step)
        begin
            if (at_origin)
            begin
                kind_reg <= s_tuser;
            end
            if (!flushing_reg || row_h)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                    if (!flushing_reg && row_last)
                    begin
                        flushing_reg <= 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            else
            begin
                flushing_reg <= 1'b0;
                row_reg      <= '0;
                col_reg      <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            motion_reg    <= (64'(count) << 16) > 64'(prod_reg);
            out_count_reg <= count32[COUNT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = motion_reg;
    assign m_tdata  = {3'b000, out_count_reg};

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !out_valid_reg)
        else $error("result produced while previous transaction pending");

    a_accept_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> row_reg < RW'(h_eff))
        else $error("pixel accepted outside the frame");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done))
        else $error("result without a finished test frame");
`endif

endmodule

`default_nettype wire
